// File: hdl/oale_pkg.sv
package oale_pkg;

  localparam int LIST_DEPTH = 256;
  localparam int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int POS_W      = 9;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W     = 32;

  localparam logic [3:0] K_INS_FRONT = 4'd0;
  localparam logic [3:0] K_INS_AT    = 4'd1;
  localparam logic [3:0] K_INS_END   = 4'd2;
  localparam logic [3:0] K_DEL_FRONT = 4'd3;
  localparam logic [3:0] K_DEL_AT    = 4'd4;
  localparam logic [3:0] K_DEL_END   = 4'd5;
  localparam logic [3:0] K_SEARCH    = 4'd6;
  localparam logic [3:0] K_READ      = 4'd7;
  localparam logic [3:0] K_CLEAR     = 4'd8;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_DRAIN_UP,
    S_WRVAL,
    S_SHIFT_DN,
    S_DRAIN_DN,
    S_SEARCH,
    S_SRCH_END,
    S_READ,
    S_READ_END,
    S_RESP
  } state_t;

endpackage

// File: hdl/ordered_array_list_engine.sv
// Path to S_RESP: insert with moves S_SHIFT_UP, S_DRAIN_UP, S_WRVAL; insert at the end S_WRVAL;
//   delete with moves S_SHIFT_DN, S_DRAIN_DN; search S_SEARCH over each entry, S_SRCH_END;
//   read S_READ, S_READ_END; refused items, empty searches, last-entry deletes, other kinds straight.
// Throughput: one item at a time; the single-port-read store walk (one entry/cycle) sets it.
// in_tready rises again once the result is in the output register.
// Reset: synchronous, active low; clears entry count and control, store contents untouched.
module ordered_array_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // value[31:0], position[40:32], zero fill
  input  logic [3:0]  in_tuser,   // kind[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], found[2], read_value[34:3],
                                  // entry_count[43:35], zero fill
);

  localparam int AW    = oale_pkg::AW;
  localparam int CNT_W = oale_pkg::CNT_W;
  localparam int CMP_W = oale_pkg::CMP_W;
  localparam int DW    = oale_pkg::DATA_W;

  oale_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [AW-1:0]    lim_r, lim_nxt;       // low bound for shift up, high bound otherwise
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [DW-1:0]    val_r, val_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [AW-1:0]    pend_waddr_r, pend_waddr_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [1:0]       st_r, st_nxt;
  logic             found_r, found_nxt;
  logic [DW-1:0]    rd_r, rd_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [47:0]      out_data_r, out_data_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [DW-1:0]    ram_wdata;
  logic [DW-1:0]    ram_rdata;

  // decode of the incoming word
  logic [3:0]       kind_in;
  logic [CMP_W-1:0] cnt_ext, cnt_m1_ext, pos_ext, ins_pos, del_pos;
  logic [CNT_W-1:0] cnt_m1;
  logic             is_ins, is_del, cnt_full, cnt_zero, ins_bad, del_bad, rd_bad;
  logic             accept, resp_load;

  assign kind_in    = in_tuser[3:0];
  assign cnt_ext    = CMP_W'(count_r);
  assign cnt_m1     = count_r - CNT_W'(1);
  assign cnt_m1_ext = cnt_ext - CMP_W'(1);
  assign pos_ext    = CMP_W'(in_tdata[40:32]);
  assign is_ins     = kind_in inside {oale_pkg::K_INS_FRONT, oale_pkg::K_INS_AT,
                                      oale_pkg::K_INS_END};
  assign is_del     = kind_in inside {oale_pkg::K_DEL_FRONT, oale_pkg::K_DEL_AT,
                                      oale_pkg::K_DEL_END};
  assign ins_pos    = (kind_in == oale_pkg::K_INS_FRONT) ? '0 :
                      (kind_in == oale_pkg::K_INS_END)   ? cnt_ext : pos_ext;
  assign del_pos    = (kind_in == oale_pkg::K_DEL_FRONT) ? '0 :
                      (kind_in == oale_pkg::K_DEL_END)   ? cnt_m1_ext : pos_ext;
  assign cnt_full   = (count_r == CNT_W'(oale_pkg::LIST_DEPTH));
  assign cnt_zero   = (count_r == '0);
  assign ins_bad    = (ins_pos > cnt_ext);
  assign del_bad    = cnt_zero || (del_pos >= cnt_ext);
  assign rd_bad     = (pos_ext >= cnt_ext);

  assign in_tready  = (state_r == oale_pkg::S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign resp_load  = (state_r == oale_pkg::S_RESP) && (!out_valid_r || out_tready);

  // one write port: pending shift move, else the inserted value
  assign ram_we    = pend_vld_r || (state_r == oale_pkg::S_WRVAL);
  assign ram_waddr = pend_vld_r ? pend_waddr_r : pos_r;
  assign ram_wdata = pend_vld_r ? ram_rdata : val_r;

  oale_ram #(
    .WIDTH (DW),
    .DEPTH (oale_pkg::LIST_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oale_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = oale_pkg::S_RESP;
          if (is_ins) begin
            if (!ins_bad && !cnt_full) begin
              state_nxt = (ins_pos == cnt_ext) ? oale_pkg::S_WRVAL : oale_pkg::S_SHIFT_UP;
            end
          end else if (is_del) begin
            if (!del_bad && (del_pos != cnt_m1_ext)) begin
              state_nxt = oale_pkg::S_SHIFT_DN;
            end
          end else if (kind_in == oale_pkg::K_SEARCH) begin
            if (!cnt_zero) begin
              state_nxt = oale_pkg::S_SEARCH;
            end
          end else if (kind_in == oale_pkg::K_READ) begin
            if (!rd_bad) begin
              state_nxt = oale_pkg::S_READ;
            end
          end
        end
      end
      oale_pkg::S_SHIFT_UP: begin
        if (addr_r == lim_r) state_nxt = oale_pkg::S_DRAIN_UP;
      end
      oale_pkg::S_DRAIN_UP: state_nxt = oale_pkg::S_WRVAL;
      oale_pkg::S_WRVAL:    state_nxt = oale_pkg::S_RESP;
      oale_pkg::S_SHIFT_DN: begin
        if (addr_r == lim_r) state_nxt = oale_pkg::S_DRAIN_DN;
      end
      oale_pkg::S_DRAIN_DN: state_nxt = oale_pkg::S_RESP;
      oale_pkg::S_SEARCH: begin
        if (addr_r == lim_r) state_nxt = oale_pkg::S_SRCH_END;
      end
      oale_pkg::S_SRCH_END: state_nxt = oale_pkg::S_RESP;
      oale_pkg::S_READ:     state_nxt = oale_pkg::S_READ_END;
      oale_pkg::S_READ_END: state_nxt = oale_pkg::S_RESP;
      oale_pkg::S_RESP: begin
        if (resp_load) state_nxt = oale_pkg::S_IDLE;
      end
      default: state_nxt = oale_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt      = count_r;
    addr_nxt       = addr_r;
    lim_nxt        = lim_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    pend_vld_nxt   = 1'b0;
    pend_waddr_nxt = pend_waddr_r;
    cmp_vld_nxt    = 1'b0;
    st_nxt         = st_r;
    found_nxt      = found_r;
    rd_nxt         = rd_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;

    case (state_r)
      oale_pkg::S_IDLE: begin
        if (accept) begin
          val_nxt   = in_tdata[31:0];
          st_nxt    = oale_pkg::ST_DONE;
          found_nxt = 1'b0;
          rd_nxt    = '0;
          if (is_ins) begin
            pos_nxt  = ins_pos[AW-1:0];
            lim_nxt  = ins_pos[AW-1:0];
            addr_nxt = cnt_m1[AW-1:0];
            if (ins_bad)       st_nxt = oale_pkg::ST_IGNORED;
            else if (cnt_full) st_nxt = oale_pkg::ST_FULL;
          end else if (is_del) begin
            addr_nxt = del_pos[AW-1:0] + AW'(1);
            lim_nxt  = cnt_m1[AW-1:0];
            if (del_bad) begin
              st_nxt = oale_pkg::ST_IGNORED;
            end else if (del_pos == cnt_m1_ext) begin
              count_nxt = cnt_m1;    // last entry: nothing to move
            end
          end else begin
            case (kind_in)
              oale_pkg::K_SEARCH: begin
                addr_nxt = '0;
                lim_nxt  = cnt_m1[AW-1:0];
              end
              oale_pkg::K_READ: begin
                addr_nxt = pos_ext[AW-1:0];
                if (rd_bad) st_nxt = oale_pkg::ST_IGNORED;
              end
              oale_pkg::K_CLEAR: count_nxt = '0;
              default: st_nxt = oale_pkg::ST_IGNORED;
            endcase
          end
        end
      end
      oale_pkg::S_SHIFT_UP: begin
        pend_vld_nxt   = 1'b1;
        pend_waddr_nxt = addr_r + AW'(1);
        if (addr_r != lim_r) addr_nxt = addr_r - AW'(1);
      end
      oale_pkg::S_WRVAL: count_nxt = count_r + CNT_W'(1);
      oale_pkg::S_SHIFT_DN: begin
        pend_vld_nxt   = 1'b1;
        pend_waddr_nxt = addr_r - AW'(1);
        if (addr_r != lim_r) addr_nxt = addr_r + AW'(1);
      end
      oale_pkg::S_DRAIN_DN: count_nxt = cnt_m1;
      oale_pkg::S_SEARCH: begin
        cmp_vld_nxt = 1'b1;
        if (addr_r != lim_r) addr_nxt = addr_r + AW'(1);
      end
      oale_pkg::S_READ_END: rd_nxt = ram_rdata;
      oale_pkg::S_RESP: begin
        if (resp_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, cnt_ext[8:0], rd_r, found_r, st_r};
        end
      end
      default: ;
    endcase

    // compare uses the registered read data in the cycle after the read
    if (cmp_vld_r && (ram_rdata == val_r)) found_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oale_pkg::S_IDLE;
      count_r     <= '0;
      pend_vld_r  <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_vld_r  <= pend_vld_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    lim_r        <= lim_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    pend_waddr_r <= pend_waddr_nxt;
    st_r         <= st_nxt;
    found_r      <= found_nxt;
    rd_r         <= rd_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(oale_pkg::LIST_DEPTH))
    else $error("entry count beyond store depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == oale_pkg::S_WRVAL) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not add one entry");

  a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (state_r == oale_pkg::S_SHIFT_UP || state_r == oale_pkg::S_DRAIN_UP ||
                    state_r == oale_pkg::S_SHIFT_DN || state_r == oale_pkg::S_DRAIN_DN))
    else $error("store move pending outside a shift");

endmodule

// File: hdl/oale_ram.sv
module oale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
